>>> src/assert_macros.svh
// Assertion macros shared by the RTL. Each use samples on the rising edge of clk and is
// switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

>>> src/tbsg_pkg.sv
package tbsg_pkg;

  localparam int NUM_AXES = 3;
  localparam int FIELD_W  = 20;
  localparam int ACC_W    = 21;
  localparam int REASON_W = 4;
  localparam int QUEUED_W = 6;

  localparam logic [2:0] FUNC_PUSH      = 3'd0;
  localparam logic [2:0] FUNC_TICK      = 3'd1;
  localparam logic [2:0] FUNC_CLEAR     = 3'd2;
  localparam logic [2:0] FUNC_ESTOP     = 3'd3;
  localparam logic [2:0] FUNC_CLR_FAULT = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_TICK,
    OP_CLEAR,
    OP_ESTOP,
    OP_CLR_FAULT,
    OP_STATUS
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    op_t                               op;
    logic [NUM_AXES-1:0][FIELD_W-1:0]  delta;
    logic [FIELD_W-1:0]                duration;
    logic [REASON_W-1:0]               reason;
    logic                              shape_ok;
  } cmd_t;

  typedef struct packed {
    logic                 accepted;
    logic [NUM_AXES-1:0]  step;
    logic [NUM_AXES-1:0]  dir;
    logic                 busy;
    logic                 fault;
    logic [REASON_W-1:0]  fault_code;
    logic [QUEUED_W-1:0]  queued;
  } res_t;

  // Magnitude of a two's complement count; the most negative value maps to 2^19.
  function automatic logic [FIELD_W-1:0] mag_of(input logic [FIELD_W-1:0] raw);
    return raw[FIELD_W-1] ? (~raw + FIELD_W'(1)) : raw;
  endfunction

endpackage

>>> src/three_axis_bresenham_step_generator.sv
// Channel   Handshake              Payload
// command   push / full            func, delta_first..third, duration_ticks, stop_reason
// result    pop / empty            accepted, step_*, dir_*, busy_res, fault, fault_code, queued
//
// The executor takes each command in turn: in BK_IDLE it pulls it and reads the frame store
// port, in BK_EXEC it commits state and writes the result, and it pulls no new command
// until that result is written.
// Reset (rst, synchronous) clears pointers, status and axis state; the frame
// store itself is not cleared, as only written slots are ever used.
// A two-deep command queue and a two-deep result queue part the sides; the executor holds
// its result while the result queue is full.
`include "assert_macros.svh"

module three_axis_bresenham_step_generator #(
  parameter int QUEUE_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         func,
  input  logic signed [19:0] delta_first,
  input  logic signed [19:0] delta_second,
  input  logic signed [19:0] delta_third,
  input  logic [19:0]        duration_ticks,
  input  logic [3:0]         stop_reason,
  output logic               empty,
  input  logic               pop,
  output logic               accepted,
  output logic               step_first,
  output logic               step_second,
  output logic               step_third,
  output logic               dir_first,
  output logic               dir_second,
  output logic               dir_third,
  output logic               busy_res,
  output logic               fault,
  output logic [3:0]         fault_code,
  output logic [5:0]         queued
);
  import tbsg_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  // Front: classify each command and hold it until the executor is free.
  tbsg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .delta_first    (delta_first),
    .delta_second   (delta_second),
    .delta_third    (delta_third),
    .duration_ticks (duration_ticks),
    .stop_reason    (stop_reason),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Back: frame queue, Bresenham accumulators and fault handling.
  tbsg_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Results wait here until the consumer takes the transfer.
  tbsg_res_fifo u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_full (res_full),
    .wr_data (res_in),
    .empty   (empty),
    .pop     (pop),
    .rd_data (res_out)
  );

  assign accepted    = res_out.accepted;
  assign step_first  = res_out.step[0];
  assign step_second = res_out.step[1];
  assign step_third  = res_out.step[2];
  assign dir_first   = res_out.dir[0];
  assign dir_second  = res_out.dir[1];
  assign dir_third   = res_out.dir[2];
  assign busy_res    = res_out.busy;
  assign fault       = res_out.fault;
  assign fault_code  = res_out.fault_code;
  assign queued      = res_out.queued;

  // A faulted block never runs a frame.
  `ASSERT_NEVER(a_fault_not_busy, !empty && fault && busy_res, "frame running while faulted")
  // The reason code is only held while faulted.
  `ASSERT_NEVER(a_code_needs_fault, !empty && !fault && (fault_code != 4'd0), "stale fault code")
  // A push never succeeds while faulted, and a push leaves the fault alone.
  `ASSERT_NEVER(a_no_accept_faulted, !empty && accepted && fault, "push taken while faulted")
  // Nothing is offered in the cycle after reset.
  `ASSERT_CLK(a_empty_after_rst, $past(rst) |-> empty, "result offered straight after reset")

endmodule

>>> src/tbsg_front.sv
module tbsg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          func,
  input  logic [19:0]         delta_first,
  input  logic [19:0]         delta_second,
  input  logic [19:0]         delta_third,
  input  logic [19:0]         duration_ticks,
  input  logic [3:0]          stop_reason,
  output logic                cmd_valid,
  output tbsg_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);
  import tbsg_pkg::*;

  cmd_t       cls;
  cmd_t       slot [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] cnt;
  logic       take;

  // Decode the command and check the frame shape ahead of the executor.
  always_comb begin
    unique case (func)
      FUNC_PUSH:      cls.op = OP_PUSH;
      FUNC_TICK:      cls.op = OP_TICK;
      FUNC_CLEAR:     cls.op = OP_CLEAR;
      FUNC_ESTOP:     cls.op = OP_ESTOP;
      FUNC_CLR_FAULT: cls.op = OP_CLR_FAULT;
      default:        cls.op = OP_STATUS;
    endcase
    cls.delta[0] = delta_first;
    cls.delta[1] = delta_second;
    cls.delta[2] = delta_third;
    cls.duration = duration_ticks;
    cls.reason   = stop_reason;
    cls.shape_ok = (duration_ticks != '0) &&
                   (mag_of(delta_first)  <= duration_ticks) &&
                   (mag_of(delta_second) <= duration_ticks) &&
                   (mag_of(delta_third)  <= duration_ticks);
  end

  assign full      = (cnt == 2'd2);
  assign take      = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slot[rd_sel];

  always_ff @(posedge clk) begin
    if (take) begin
      slot[wr_sel] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (take) begin
        wr_sel <= ~wr_sel;
      end
      if (cmd_pop) begin
        rd_sel <= ~rd_sel;
      end
      cnt <= cnt + 2'(take) - 2'(cmd_pop);
    end
  end

endmodule

>>> src/tbsg_back.sv
module tbsg_back #(
  parameter int QUEUE_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  tbsg_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output tbsg_pkg::res_t      res
);
  import tbsg_pkg::*;

  localparam int PW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CW  = (PW > QUEUED_W) ? PW : QUEUED_W;
  localparam int ENT = NUM_AXES * FIELD_W + FIELD_W;

  bk_state_t state, state_next;

  logic [ENT-1:0] frame_mem [QUEUE_SLOTS];
  logic [ENT-1:0] rd_data;
  cmd_t           cur;

  logic [PW-1:0]        wp, rp, wp_next, rp_next, wp_inc, qcount;
  logic                 running, running_next;
  logic                 faulted, faulted_next;
  logic [REASON_W-1:0]  reason, reason_next;
  logic [FIELD_W-1:0]   tick_count, tick_count_next, tc_inc;
  logic [FIELD_W-1:0]   cur_dur, cur_dur_next, src_dur, rd_dur;
  logic [NUM_AXES-1:0][FIELD_W-1:0] mag, mag_next, src_mag;
  logic [NUM_AXES-1:0][ACC_W-1:0]   acc, acc_next, src_acc, sum;
  logic [NUM_AXES-1:0]  dir, dir_next, steps;
  logic                 push_ok, do_tick, start;
  logic [CW-1:0]        qcount_ext;

  assign rd_dur = rd_data[FIELD_W-1:0];

  // Per item: pull and read the frame store, then commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur     <= cmd;
      rd_data <= frame_mem[rp];
    end
    if (res_push && push_ok) begin
      frame_mem[wp] <= {cur.delta, cur.duration};
    end
  end

  assign wp_inc  = (wp == PW'(QUEUE_SLOTS - 1)) ? '0 : wp + PW'(1);
  assign push_ok = (cur.op == OP_PUSH) && !faulted && cur.shape_ok && (wp_inc != rp);
  assign do_tick = (cur.op == OP_TICK) && !faulted && (running || (rp != wp));
  assign start   = do_tick && !running;

  // Tick datapath: a fresh frame takes its values from the store read.
  always_comb begin
    src_dur = start ? rd_dur : cur_dur;
    for (int a = 0; a < NUM_AXES; a++) begin
      src_mag[a] = start ? mag_of(rd_data[FIELD_W*(a+1) +: FIELD_W]) : mag[a];
      src_acc[a] = start ? ACC_W'(rd_dur[FIELD_W-1:1]) : acc[a];
      sum[a]     = src_acc[a] + ACC_W'(src_mag[a]);
      steps[a]   = do_tick && (sum[a] >= ACC_W'(src_dur));
    end
    tc_inc = (start ? '0 : tick_count) + FIELD_W'(1);
  end

  always_comb begin
    wp_next         = wp;
    rp_next         = rp;
    running_next    = running;
    faulted_next    = faulted;
    reason_next     = reason;
    tick_count_next = tick_count;
    cur_dur_next    = cur_dur;
    mag_next        = mag;
    acc_next        = acc;
    dir_next        = dir;
    unique case (cur.op)
      OP_PUSH: begin
        if (push_ok) begin
          wp_next = wp_inc;
        end
      end
      OP_TICK: begin
        if (do_tick) begin
          if (start) begin
            rp_next      = (rp == PW'(QUEUE_SLOTS - 1)) ? '0 : rp + PW'(1);
            cur_dur_next = rd_dur;
            for (int a = 0; a < NUM_AXES; a++) begin
              dir_next[a] = ~rd_data[FIELD_W*(a+2)-1];
            end
          end
          mag_next = src_mag;
          for (int a = 0; a < NUM_AXES; a++) begin
            acc_next[a] = steps[a] ? sum[a] - ACC_W'(src_dur) : sum[a];
          end
          tick_count_next = tc_inc;
          running_next    = !(tc_inc >= src_dur);
        end
      end
      OP_CLEAR: rp_next = wp;
      OP_ESTOP: begin
        wp_next         = '0;
        rp_next         = '0;
        running_next    = 1'b0;
        tick_count_next = '0;
        acc_next        = '0;
        faulted_next    = 1'b1;
        reason_next     = cur.reason;
      end
      OP_CLR_FAULT: begin
        faulted_next = 1'b0;
        reason_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      running    <= 1'b0;
      faulted    <= 1'b0;
      reason     <= '0;
      tick_count <= '0;
      cur_dur    <= '0;
      mag        <= '0;
      acc        <= '0;
      dir        <= '0;
    end else if (res_push) begin
      wp         <= wp_next;
      rp         <= rp_next;
      running    <= running_next;
      faulted    <= faulted_next;
      reason     <= reason_next;
      tick_count <= tick_count_next;
      cur_dur    <= cur_dur_next;
      mag        <= mag_next;
      acc        <= acc_next;
      dir        <= dir_next;
    end
  end

  always_comb begin
    qcount = wp_next - rp_next;
    if (wp_next < rp_next) begin
      qcount = qcount + PW'(QUEUE_SLOTS);
    end
    qcount_ext = CW'(qcount);
  end

  always_comb begin
    res.accepted   = push_ok;
    res.step       = steps;
    res.dir        = dir_next;
    res.busy       = running_next;
    res.fault      = faulted_next;
    res.fault_code = reason_next;
    res.queued     = qcount_ext[QUEUED_W-1:0];
  end

endmodule

>>> src/tbsg_res_fifo.sv
module tbsg_res_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  output logic            wr_full,
  input  tbsg_pkg::res_t  wr_data,
  output logic            empty,
  input  logic            pop,
  output tbsg_pkg::res_t  rd_data
);
  import tbsg_pkg::*;

  res_t       slot [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] cnt;
  logic       take;
  logic       give;

  assign wr_full = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign take    = wr && !wr_full;
  assign give    = pop && !empty;
  assign rd_data = slot[rd_sel];

  always_ff @(posedge clk) begin
    if (take) begin
      slot[wr_sel] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (take) begin
        wr_sel <= ~wr_sel;
      end
      if (give) begin
        rd_sel <= ~rd_sel;
      end
      cnt <= cnt + 2'(take) - 2'(give);
    end
  end

endmodule

>>> bench/tb_three_axis_bresenham_step_generator.sv
`timescale 1ns / 1ps

module tb_three_axis_bresenham_step_generator;
  import tbsg_pkg::*;

  localparam int QUEUE_SLOTS  = 64;
  localparam int HALF_PERIOD  = 4;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 24;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_PRINTED  = 40;

  // Command codes the block leaves unused; they only report status.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Field extremes: most negative and most positive count, longest and half-range duration.
  localparam logic [FIELD_W-1:0] CNT_MIN  = 20'h80000;
  localparam logic [FIELD_W-1:0] CNT_MAX  = 20'h7FFFF;
  localparam logic [FIELD_W-1:0] LEN_MAX  = 20'hFFFFF;
  localparam logic [FIELD_W-1:0] LEN_HALF = 20'h80000;

  typedef struct {
    logic [2:0]                       code;
    logic [NUM_AXES-1:0][FIELD_W-1:0] count;
    logic [FIELD_W-1:0]               len;
    logic [REASON_W-1:0]              reason;
    bit                               wait_idle;  // hold off until every status is back
  } motion_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               push = 1'b0;
  logic               full;
  logic [2:0]         func = FUNC_TICK;
  logic signed [19:0] delta_first = '0;
  logic signed [19:0] delta_second = '0;
  logic signed [19:0] delta_third = '0;
  logic [19:0]        duration_ticks = '0;
  logic [3:0]         stop_reason = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               accepted;
  logic               step_first;
  logic               step_second;
  logic               step_third;
  logic               dir_first;
  logic               dir_second;
  logic               dir_third;
  logic               busy_res;
  logic               fault;
  logic [3:0]         fault_code;
  logic [5:0]         queued;

  three_axis_bresenham_step_generator #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_dut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stepper state as the block should hold it: frame ring, running frame,
  // fault latch and the three Bresenham accumulators.
  // ---------------------------------------------------------------------------
  logic [NUM_AXES-1:0][FIELD_W-1:0] slot_count [QUEUE_SLOTS];
  logic [FIELD_W-1:0]               slot_len [QUEUE_SLOTS];
  int                               wr_ptr;
  int                               rd_ptr;
  bit                               motion_on;
  bit                               fault_on;
  logic [REASON_W-1:0]              fault_reason;
  logic [FIELD_W-1:0]               ticks_done;
  logic [FIELD_W-1:0]               frame_len;
  logic [FIELD_W-1:0]               axis_mag [NUM_AXES];
  logic [FIELD_W:0]                 axis_acc [NUM_AXES];
  bit                               axis_dir [NUM_AXES];

  motion_cmd_t command_q[$];   // every command, in the order it is offered
  res_t        forecast_q[$];  // status the block owes, one per transferred command

  int  cmd_idx = 0;      // next command to offer (driver only)
  int  n_sent = 0;       // commands transferred (driver only)
  int  n_forecast = 0;   // copy of n_sent for the other processes
  int  n_checked = 0;    // statuses transferred and compared (monitor only)
  int  err_count = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  bit  offer;
  int  hold_left = 0;
  int  stall_left = 0;
  int  stall_pct = 0;
  int  cycle_count = 0;
  bit  drain_next = 1'b0;
  bit  gen_faulted = 1'b0;

  // Magnitude of a two's complement count; the most negative one gives 2^19.
  function automatic logic [FIELD_W:0] count_magnitude(logic [FIELD_W-1:0] raw);
    return raw[FIELD_W-1] ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
  endfunction

  function automatic void reset_forecast();
    wr_ptr       = 0;
    rd_ptr       = 0;
    motion_on    = 1'b0;
    fault_on     = 1'b0;
    fault_reason = '0;
    ticks_done   = '0;
    frame_len    = '0;
    foreach (axis_mag[a]) begin
      axis_mag[a] = '0;
      axis_acc[a] = '0;
      axis_dir[a] = 1'b0;
    end
  endfunction

  // Advance the stepper state by one command and return the status it reports.
  function automatic res_t forecast_status(motion_cmd_t c);
    res_t r;
    int   nxt;
    r = '0;
    case (c.code)
      FUNC_PUSH: begin
        nxt = (wr_ptr + 1) % QUEUE_SLOTS;
        if (!fault_on && nxt != rd_ptr && c.len != '0 &&
            count_magnitude(c.count[0]) <= c.len &&
            count_magnitude(c.count[1]) <= c.len &&
            count_magnitude(c.count[2]) <= c.len) begin
          slot_count[wr_ptr] = c.count;
          slot_len[wr_ptr]   = c.len;
          wr_ptr             = nxt;
          r.accepted         = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (!fault_on && (motion_on || rd_ptr != wr_ptr)) begin
          // load the next frame: directions from the signs, accumulators at half length
          if (!motion_on) begin
            frame_len  = slot_len[rd_ptr];
            for (int a = 0; a < NUM_AXES; a++) begin
              axis_dir[a] = ~slot_count[rd_ptr][a][FIELD_W-1];
              axis_mag[a] = FIELD_W'(count_magnitude(slot_count[rd_ptr][a]));
              axis_acc[a] = {1'b0, frame_len >> 1};
            end
            rd_ptr     = (rd_ptr + 1) % QUEUE_SLOTS;
            motion_on  = 1'b1;
            ticks_done = '0;
          end
          for (int a = 0; a < NUM_AXES; a++) begin
            axis_acc[a] = axis_acc[a] + axis_mag[a];
            if (axis_acc[a] >= frame_len) begin
              r.step[a]   = 1'b1;
              axis_acc[a] = axis_acc[a] - frame_len;
            end
          end
          ticks_done = ticks_done + 1'b1;
          if (ticks_done >= frame_len) motion_on = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        rd_ptr = wr_ptr;
      end
      FUNC_ESTOP: begin
        wr_ptr     = 0;
        rd_ptr     = 0;
        motion_on  = 1'b0;
        ticks_done = '0;
        foreach (axis_acc[a]) axis_acc[a] = '0;
        fault_on     = 1'b1;
        fault_reason = c.reason;
      end
      FUNC_CLR_FAULT: begin
        fault_on     = 1'b0;
        fault_reason = '0;
      end
      default: begin
      end
    endcase
    for (int a = 0; a < NUM_AXES; a++) r.dir[a] = axis_dir[a];
    r.busy       = motion_on;
    r.fault      = fault_on;
    r.fault_code = fault_reason;
    r.queued     = QUEUED_W'((wr_ptr - rd_ptr + QUEUE_SLOTS) % QUEUE_SLOTS);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [FIELD_W-1:0] noise_word();
    return FIELD_W'($urandom());
  endfunction

  // Random count whose magnitude does not exceed len; full magnitude now and then.
  function automatic logic [FIELD_W-1:0] rand_count(logic [FIELD_W-1:0] len);
    logic [FIELD_W:0] cap;
    logic [FIELD_W:0] m;
    cap = (len > LEN_HALF) ? {1'b0, LEN_HALF} : {1'b0, len};
    m   = ($urandom_range(0, 7) == 0) ? cap : (FIELD_W+1)'($urandom_range(0, cap));
    if (m == {1'b0, LEN_HALF} || $urandom_range(0, 1) == 1) return -m[FIELD_W-1:0];
    return m[FIELD_W-1:0];
  endfunction

  function automatic void queue_cmd(logic [2:0] code, logic [FIELD_W-1:0] c0, c1, c2, len,
                                    logic [REASON_W-1:0] why);
    motion_cmd_t c;
    c.code      = code;
    c.count[0]  = c0;
    c.count[1]  = c1;
    c.count[2]  = c2;
    c.len       = len;
    c.reason    = why;
    c.wait_idle = drain_next;
    drain_next  = 1'b0;
    if (code == FUNC_ESTOP) gen_faulted = 1'b1;
    else if (code == FUNC_CLR_FAULT) gen_faulted = 1'b0;
    command_q.push_back(c);
  endfunction

  // Command whose payload the block ignores: fill it with noise.
  function automatic void queue_bare(logic [2:0] code);
    queue_cmd(code, noise_word(), noise_word(), noise_word(), noise_word(),
              REASON_W'($urandom()));
  endfunction

  function automatic void queue_frame(logic [FIELD_W-1:0] len);
    queue_cmd(FUNC_PUSH, rand_count(len), rand_count(len), rand_count(len), len,
              REASON_W'($urandom()));
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string what, int n, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("status %0d %s: got %0h, want %0h", n, what, got, want));
  endtask

  task automatic compare_status(int n, res_t want);
    check_field("accepted", n, 8'(accepted), 8'(want.accepted));
    check_field("step_first", n, 8'(step_first), 8'(want.step[0]));
    check_field("step_second", n, 8'(step_second), 8'(want.step[1]));
    check_field("step_third", n, 8'(step_third), 8'(want.step[2]));
    check_field("dir_first", n, 8'(dir_first), 8'(want.dir[0]));
    check_field("dir_second", n, 8'(dir_second), 8'(want.dir[1]));
    check_field("dir_third", n, 8'(dir_third), 8'(want.dir[2]));
    check_field("busy_res", n, 8'(busy_res), 8'(want.busy));
    check_field("fault", n, 8'(fault), 8'(want.fault));
    check_field("fault_code", n, 8'(fault_code), 8'(want.fault_code));
    check_field("queued", n, 8'(queued), 8'(want.queued));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer commands in bursts with random gaps. An offer the block has
  // not taken is held unchanged; the forecast advances on every transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      reset_forecast();
    end else begin
      if (push && !full) begin
        forecast_q.push_back(forecast_status(command_q[cmd_idx]));
        cmd_idx++;
        n_sent++;
        n_forecast <= n_sent;
        if (burst_left > 0) burst_left--;
      end
      if (!(push && full)) begin
        offer = 1'b0;
        if (cmd_idx < command_q.size()) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
          end
          if (gap_left > 0) gap_left--;
          // pause here until every outstanding status has come back
          else if (command_q[cmd_idx].wait_idle && n_checked != n_sent) offer = 1'b0;
          else offer = 1'b1;
          func           <= command_q[cmd_idx].code;
          delta_first    <= command_q[cmd_idx].count[0];
          delta_second   <= command_q[cmd_idx].count[1];
          delta_third    <= command_q[cmd_idx].count[2];
          duration_ticks <= command_q[cmd_idx].len;
          stop_reason    <= command_q[cmd_idx].reason;
        end
        push <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every status transfer with the oldest forecast. Pop on a
  // stall pattern whose density is redrawn when stall_left runs out, and hold
  // off for a long stretch twice so that the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (n_checked >= n_forecast) begin
          report_mismatch("status transfer with no command outstanding");
        end else begin
          compare_status(n_checked, forecast_q[n_checked]);
          n_checked <= n_checked + 1;
          if (n_checked + 1 == 200 || n_checked + 1 == 1000) hold_left = HOLD_CYCLES;
        end
      end
      if (stall_left == 0) begin
        stall_left = 50;
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        stall_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: drop the run if it stalls.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      report_mismatch($sformatf("timeout with %0d statuses outstanding",
                                n_forecast - n_checked));
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Build the command list, release reset, then wait for the last status.
  // ---------------------------------------------------------------------------
  initial begin
    int                               directed_end;
    int                               pick;
    int                               nf;
    int                               nt;
    int                               total;
    int                               a;
    logic [FIELD_W-1:0]               len;
    logic [FIELD_W-1:0]               bad;
    logic [NUM_AXES-1:0][FIELD_W-1:0] cnt;

    // Directed opening: idle tick, rejected pushes, count extremes, every command,
    // clear queue under a running frame, stop with reason zero, commands while faulted.
    queue_bare(FUNC_TICK);
    queue_cmd(FUNC_PUSH, 20'd1, 20'd0, 20'd0, 20'd0, 4'd2);
    queue_cmd(FUNC_PUSH, 20'd4, -20'sd5, 20'd0, 20'd4, 4'd0);
    queue_cmd(FUNC_PUSH, 20'd1, -20'sd1, 20'd0, 20'd1, 4'd0);
    queue_cmd(FUNC_PUSH, CNT_MIN, CNT_MIN, CNT_MIN, LEN_HALF, 4'd0);
    queue_cmd(FUNC_PUSH, CNT_MAX, -CNT_MAX, 20'd0, LEN_MAX, 4'd15);
    queue_cmd(FUNC_PUSH, CNT_MIN, 20'd0, 20'd0, CNT_MAX, 4'd0);
    queue_bare(FUNC_TICK);
    queue_bare(FUNC_TICK);
    queue_bare(FUNC_TICK);
    queue_bare(FUNC_CLEAR);
    queue_bare(FUNC_TICK);
    queue_bare(FUNC_SPARE_LO);
    queue_bare(FUNC_SPARE_HI);
    queue_cmd(FUNC_ESTOP, noise_word(), noise_word(), noise_word(), noise_word(), 4'd0);
    queue_frame(20'd3);
    queue_bare(FUNC_TICK);
    queue_bare(FUNC_CLEAR);
    queue_bare(FUNC_CLR_FAULT);
    queue_cmd(FUNC_ESTOP, noise_word(), noise_word(), noise_word(), noise_word(), 4'd15);
    queue_bare(FUNC_CLR_FAULT);
    queue_cmd(FUNC_PUSH, 20'd3, -20'sd2, 20'd1, 20'd4, 4'd0);
    repeat (4) queue_bare(FUNC_TICK);
    directed_end = command_q.size();
    drain_next   = 1'b1;

    // Random part: mostly well-formed frame sequences followed by their ticks,
    // the rest broken sequences, stops, queue clears and noise.
    while (command_q.size() < directed_end + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if (gen_faulted) queue_bare(FUNC_CLR_FAULT);
        nf    = $urandom_range(1, 4);
        total = 0;
        for (int k = 0; k < nf; k++) begin
          if ($urandom_range(0, 49) == 0) begin
            len   = FIELD_W'($urandom_range(13, LEN_MAX));
            total += $urandom_range(5, 30);
          end else begin
            len   = FIELD_W'($urandom_range(1, 12));
            total += int'(len);
          end
          queue_frame(len);
        end
        nt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total) : total + $urandom_range(0, 3);
        if (nt > 60) nt = 60;
        for (int t = 0; t < nt; t++) begin
          if ($urandom_range(0, 15) == 0) queue_frame(FIELD_W'($urandom_range(1, 12)));
          else queue_bare(FUNC_TICK);
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 5)) queue_bare(FUNC_TICK);
      end else if (pick < 71) begin
        // rejected push: zero length, or one count longer than the frame
        len = FIELD_W'($urandom_range(0, 1000));
        if (len == '0 || $urandom_range(0, 1) == 1) begin
          queue_cmd(FUNC_PUSH, noise_word(), noise_word(), noise_word(), 20'd0,
                    REASON_W'($urandom()));
        end else begin
          for (int k = 0; k < NUM_AXES; k++) cnt[k] = rand_count(len);
          a   = $urandom_range(0, NUM_AXES - 1);
          bad = len + FIELD_W'($urandom_range(1, 6));
          cnt[a] = ($urandom_range(0, 1) == 1) ? -bad : bad;
          queue_cmd(FUNC_PUSH, cnt[0], cnt[1], cnt[2], len, REASON_W'($urandom()));
        end
      end else if (pick < 76) begin
        queue_bare(FUNC_CLEAR);
      end else if (pick < 83) begin
        queue_cmd(FUNC_ESTOP, noise_word(), noise_word(), noise_word(), noise_word(),
                  REASON_W'($urandom()));
        repeat ($urandom_range(0, 3)) queue_bare(3'($urandom_range(0, 7)));
        if ($urandom_range(0, 5) != 0) queue_bare(FUNC_CLR_FAULT);
      end else if (pick < 87) begin
        queue_bare(FUNC_CLR_FAULT);
      end else if (pick < 91) begin
        queue_bare(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)));
      end else if (pick < 95) begin
        // fill the frame ring to near or past its limit, then clear, stop or let it drain
        if (gen_faulted) queue_bare(FUNC_CLR_FAULT);
        repeat ($urandom_range(QUEUE_SLOTS - 2, QUEUE_SLOTS + 2))
          queue_frame(FIELD_W'($urandom_range(1, 3)));
        case ($urandom_range(0, 4))
          0, 1, 2: queue_bare(FUNC_CLEAR);
          3:       queue_cmd(FUNC_ESTOP, noise_word(), noise_word(), noise_word(),
                             noise_word(), REASON_W'($urandom()));
          default: repeat (20) queue_bare(FUNC_TICK);
        endcase
      end else if (pick < 98) begin
        queue_frame(FIELD_W'($urandom_range(1, LEN_MAX)));
      end else begin
        drain_next = 1'b1;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait until every command is taken and every status is back, then a short tail
    // in which no further status may appear.
    while (cmd_idx < command_q.size() || n_checked != n_forecast) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
